### src/spq_pkg.sv
// Shared types and constants for the sorted insertion priority queue.
// No dependencies; every other file in the project imports this package.
package spq_pkg;

  // Fixed field widths of a request and a response beat.
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  // Default number of queue entries.
  localparam int DEPTH_DEFAULT = 16;

  // Operation codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic op;
  } spq_cmd_t;

  // Outcome of one operation, from the datapath back to the controller.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
    logic [OCC_W-1:0]  occupancy;
  } spq_result_t;

endpackage

### src/spq_ifs.sv
// Handshake interfaces for the request and response channels.
// Depends on spq_pkg for the field widths.

interface spq_req_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] item_priority;

  modport source (output valid, output operation, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input operation, input item_value, input item_priority,
                  output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] out_value;
  logic signed [DATA_W-1:0] out_priority;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output out_value, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_value, input out_priority,
                  input occupancy, output ready);
endinterface

### src/spq_datapath.sv
// Datapath of the priority queue: a row of sorted cells and the entry count.
// Depends on spq_pkg for the command and result types.
module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::spq_cmd_t                cmd,
  input  logic signed [spq_pkg::DATA_W-1:0] item_value,
  input  logic signed [spq_pkg::DATA_W-1:0] item_priority,
  output spq_pkg::spq_result_t             result
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Cell contents; entry 0 is the head. Only the first count cells are meaningful.
  logic signed [DATA_W-1:0] cell_value    [DEPTH];
  logic signed [DATA_W-1:0] cell_priority [DEPTH];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic [DEPTH-1:0] stay;
  logic             full;
  logic             empty;
  logic             do_enq;
  logic             do_deq;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_enq = cmd.exec && (cmd.op == OP_ENQUEUE) && !full;
  assign do_deq = cmd.exec && (cmd.op == OP_DEQUEUE) && !empty;

  // Each cell holding a priority no larger than the new one stays put. Since the row is
  // sorted these cells form a prefix, and the new entry lands just behind it.
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign stay[i] = (CNT_W'(i) < count) && (cell_priority[i] <= item_priority);

      always_ff @(posedge clk) begin
        if (do_enq && !stay[i]) begin
          if (i == 0) begin
            cell_value[i]    <= item_value;
            cell_priority[i] <= item_priority;
          end else if (stay[(i == 0) ? 0 : i-1]) begin
            cell_value[i]    <= item_value;
            cell_priority[i] <= item_priority;
          end else begin
            cell_value[i]    <= cell_value[(i == 0) ? 0 : i-1];
            cell_priority[i] <= cell_priority[(i == 0) ? 0 : i-1];
          end
        end else if (do_deq && (i < DEPTH-1)) begin
          cell_value[i]    <= cell_value[(i < DEPTH-1) ? i+1 : i];
          cell_priority[i] <= cell_priority[(i < DEPTH-1) ? i+1 : i];
        end
      end
    end
  endgenerate

  // Entry count follows the successful operations.
  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + CNT_W'(1);
    end else if (do_deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Outcome of the operation presented this cycle.
  always_comb begin
    result.status    = ST_OK;
    result.value     = '0;
    result.prio      = '0;
    result.occupancy = OCC_W'(count_next);
    if (cmd.op == OP_ENQUEUE) begin
      if (full) begin
        result.status = ST_OVERFLOW;
      end
    end else if (empty) begin
      result.status = ST_UNDERFLOW;
    end else begin
      result.value = cell_value[0];
      result.prio  = cell_priority[0];
    end
  end

endmodule

### src/spq_controller.sv
// Controller of the priority queue: request handshake, command issue and the
// response output register. Depends on spq_pkg and the channel interfaces.
module spq_controller (
  input  logic                 clk,
  input  logic                 rst,
  spq_req_if.sink              req,
  spq_rsp_if.source            rsp,
  output spq_pkg::spq_cmd_t    cmd,
  input  spq_pkg::spq_result_t result
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic        state;
  logic        state_next;
  logic        accept;
  spq_result_t held;

  // A new request beat is taken whenever the output register is free or being emptied.
  assign req.ready = (state == S_IDLE) || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign cmd.exec = accept;
  assign cmd.op   = req.operation;

  // State transitions of the output register.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (accept) begin
          state_next = S_HOLD;
        end else if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the outcome of each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= result;
    end
  end

  assign rsp.valid        = (state == S_HOLD);
  assign rsp.status       = held.status;
  assign rsp.out_value    = held.value;
  assign rsp.out_priority = held.prio;
  assign rsp.occupancy    = held.occupancy;

endmodule

### src/sorted_insertion_priority_queue.sv
// Sorted insertion priority queue: each request beat yields one response beat, registered at the
// output and presented in the cycle after the request beat is accepted.
// Throughput is one beat per cycle while the response side is ready; the whole row of
// cells shifts and inserts at once, which bounds the clock.
// Synchronous active-high reset empties the queue and drops any pending response; cell
// contents are not cleared.
module sorted_insertion_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);
  import spq_pkg::*;

  spq_cmd_t    cmd;
  spq_result_t result;

  // Handshake and output register.
  spq_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cmd    (cmd),
    .result (result)
  );

  // Cell row and entry count.
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item_value    (req.item_value),
    .item_priority (req.item_priority),
    .result        (result)
  );

endmodule

### src/spq_checker.sv
// Port-level checks on the priority queue, bound to the top level.
// Depends on spq_pkg for the status codes and field widths.
module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [spq_pkg::STAT_W-1:0]   status,
  input logic [spq_pkg::DATA_W-1:0]   out_value,
  input logic [spq_pkg::DATA_W-1:0]   out_priority,
  input logic [spq_pkg::OCC_W-1:0]    occupancy
);
  import spq_pkg::*;

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || status == ST_OVERFLOW || status == ST_UNDERFLOW))
    else $error("undefined status code on response");

  // A failed operation returns no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (out_value == '0 && out_priority == '0))
    else $error("failed operation returned non-zero data");

  // Underflow leaves the queue empty, overflow leaves it full.
  a_fail_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((status != ST_UNDERFLOW || occupancy == '0) &&
                   (status != ST_OVERFLOW || occupancy == OCC_W'(DEPTH))))
    else $error("occupancy inconsistent with failure status");

  // A stalled response beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(occupancy)))
    else $error("stalled response beat changed");

endmodule

bind sorted_insertion_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .out_value    (rsp.out_value),
  .out_priority (rsp.out_priority),
  .occupancy    (rsp.occupancy)
);

### tb/tb_sorted_insertion_priority_queue.sv
// Self-checking testbench for the sorted insertion priority queue.
// Depends on spq_pkg, the spq_req_if and spq_rsp_if interfaces and the queue RTL.
// A predictor keeps its own sorted copy of the queue and checks every response beat.
module tb_sorted_insertion_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
  localparam int TOTAL_ITEMS  = 1250;
  localparam int QUIET_LIMIT  = 3000;
  localparam int LONG_HOLD    = 160;
  localparam int MAX_PAUSE    = 16;
  localparam int SHOWN_ERRORS = 10;
  localparam logic signed [DATA_W-1:0] PRI_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] PRI_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic                     op;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] pri;
  } queue_request_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] pri;
    logic [OCC_W-1:0]         occ;
  } queue_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_req_if req ();
  spq_rsp_if rsp ();

  // Locally held drive values give every input a known level from time zero.
  logic                     req_valid = 1'b0;
  logic                     req_op    = OP_ENQUEUE;
  logic signed [DATA_W-1:0] req_val   = '0;
  logic signed [DATA_W-1:0] req_pri   = '0;
  logic                     rsp_ready = 1'b0;

  assign req.valid         = req_valid;
  assign req.operation     = req_op;
  assign req.item_value    = req_val;
  assign req.item_priority = req_pri;
  assign rsp.ready         = rsp_ready;

  sorted_insertion_priority_queue #(.DEPTH(QUEUE_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue contents, head at index 0.
  logic signed [DATA_W-1:0] held_val [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] held_pri [QUEUE_DEPTH];
  int held_count   = 0;
  int enq_count    = 0;
  int deq_count    = 0;
  int refused_full = 0;
  int refused_empty = 0;
  int peak_occ     = 0;

  queue_request_t pending_reqs[$];
  queue_answer_t  awaited_answers[$];

  // Handshake flags, written at the rising edge and read at the falling edge.
  bit req_fire = 1'b0;
  bit rsp_fire = 1'b0;
  int beats_taken  = 0;
  int answers_seen = 0;
  int mismatches   = 0;
  int send_pause   = 0;
  int items_offered = 0;
  int rsp_hold     = 0;

  // Apply one operation to the shadow queue and return the answer it should give.
  function automatic queue_answer_t serve_request(queue_request_t r);
    queue_answer_t a;
    int slot;
    a.status = ST_OK;
    a.val    = '0;
    a.pri    = '0;
    if (r.op == OP_ENQUEUE) begin
      enq_count++;
      if (held_count >= QUEUE_DEPTH) begin
        a.status = ST_OVERFLOW;
        refused_full++;
      end else begin
        // Walk the newcomer forward past strictly larger priorities only,
        // so that equal priorities stay in arrival order.
        slot = held_count;
        while (slot > 0 && r.pri < held_pri[slot-1]) begin
          held_val[slot] = held_val[slot-1];
          held_pri[slot] = held_pri[slot-1];
          slot--;
        end
        held_val[slot] = r.val;
        held_pri[slot] = r.pri;
        held_count++;
        if (held_count > peak_occ) peak_occ = held_count;
      end
    end else begin
      deq_count++;
      if (held_count == 0) begin
        a.status = ST_UNDERFLOW;
        refused_empty++;
      end else begin
        a.val = held_val[0];
        a.pri = held_pri[0];
        for (int k = 1; k < held_count; k++) begin
          held_val[k-1] = held_val[k];
          held_pri[k-1] = held_pri[k];
        end
        held_count--;
      end
    end
    a.occ = held_count[OCC_W-1:0];
    return a;
  endfunction

  function automatic void add_request(logic op, logic signed [DATA_W-1:0] val,
                                      logic signed [DATA_W-1:0] pri);
    queue_request_t r;
    r.op  = op;
    r.val = val;
    r.pri = pri;
    pending_reqs.push_back(r);
  endfunction

  // Pause length per beat; the mode cycles through no idling, full spread and rare gaps.
  function automatic int draw_pause(int mode);
    case (mode % 3)
      0: return 0;
      1: return $urandom_range(0, MAX_PAUSE);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_PAUSE) : 0;
    endcase
  endfunction

  // Monitor: check the response beat first, then predict for the request beat.
  always @(posedge clk) begin
    queue_answer_t want;
    queue_request_t got;
    req_fire = !rst && req.valid && req.ready;
    rsp_fire = !rst && rsp.valid && rsp.ready;
    if (rsp_fire) begin
      answers_seen++;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("[%0t] response beat with nothing expected: status %0d value %0d pri %0d occ %0d",
                   $realtime, rsp.status, rsp.out_value, rsp.out_priority, rsp.occupancy);
      end else begin
        want = awaited_answers.pop_front();
        if (rsp.status !== want.status || rsp.out_value !== want.val ||
            rsp.out_priority !== want.pri || rsp.occupancy !== want.occ) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("[%0t] mismatch: expected status %0d value %0d pri %0d occ %0d, got %0d %0d %0d %0d",
                     $realtime, want.status, want.val, want.pri, want.occ,
                     rsp.status, rsp.out_value, rsp.out_priority, rsp.occupancy);
        end
      end
    end
    if (req_fire) begin
      beats_taken++;
      got.op  = req.operation;
      got.val = req.item_value;
      got.pri = req.item_priority;
      awaited_answers.push_back(serve_request(got));
    end
  end

  // Driver: present the next request once the previous beat has gone and the pause is over.
  always @(negedge clk) begin
    queue_request_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (send_pause > 0) begin
        send_pause--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        req_op    <= nxt.op;
        req_val   <= nxt.val;
        req_pri   <= nxt.pri;
        req_valid <= 1'b1;
        send_pause = draw_pause(items_offered / 150);
        items_offered++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: may stall after each response beat; twice it holds off long enough to back up
  // the request side while the driver keeps offering.
  always @(negedge clk) begin
    if (rsp_fire) begin
      rsp_hold = draw_pause(answers_seen / 110 + 1);
      if (answers_seen == 400 || answers_seen == 900) rsp_hold = LONG_HOLD;
    end
    if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog: give up when no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (req_fire || rsp_fire) quiet = 0;
      else quiet++;
    end
    $display("No beat moved for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    queue_request_t r;
    int total;
    int phase_left;
    int enq_pct;
    int pri_mode;

    // Directed part: dequeue from empty, fill with extreme and tied priorities,
    // refuse two enqueues at full (one with the smallest priority), then serve a few.
    add_request(OP_DEQUEUE, 32'sd7, 32'sd7);
    add_request(OP_ENQUEUE, 32'sd11, 32'sd0);
    add_request(OP_ENQUEUE, 32'sd12, PRI_MAX);
    add_request(OP_ENQUEUE, 32'sd13, PRI_MIN);
    add_request(OP_ENQUEUE, 32'sd21, 32'sd0);
    add_request(OP_ENQUEUE, 32'sd14, -32'sd1);
    add_request(OP_ENQUEUE, 32'sd15, 32'sd1);
    add_request(OP_ENQUEUE, 32'sd31, 32'sd0);
    add_request(OP_ENQUEUE, 32'sd22, PRI_MAX);
    add_request(OP_ENQUEUE, 32'sd23, PRI_MIN);
    add_request(OP_ENQUEUE, PRI_MAX, 32'sd5);
    add_request(OP_ENQUEUE, PRI_MIN, 32'sd5);
    add_request(OP_ENQUEUE, -32'sd1, 32'sd5);
    add_request(OP_ENQUEUE, 32'sd0, -32'sd1);
    add_request(OP_ENQUEUE, 32'sh5555_5555, 32'sd2);
    add_request(OP_ENQUEUE, 32'shAAAA_AAAA, 32'sd3);
    add_request(OP_ENQUEUE, 32'sh1234_5678, 32'sd4);
    add_request(OP_ENQUEUE, 32'sd99, 32'sd9);
    add_request(OP_ENQUEUE, 32'sd98, PRI_MIN);
    repeat (4) add_request(OP_DEQUEUE, $urandom, $urandom);

    // Random part: phases that lean towards filling, draining or churning, each with
    // its own spread of priorities so that ties and extremes turn up often.
    phase_left = 0;
    enq_pct    = 50;
    pri_mode   = 0;
    while (pending_reqs.size() < TOTAL_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
        pri_mode = $urandom_range(0, 2);
      end
      phase_left--;
      r.op  = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      r.val = $urandom;
      case (pri_mode)
        0: r.pri = $urandom;
        1: begin
          r.pri = $urandom_range(0, 3);
          r.pri = r.pri - 2;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: r.pri = PRI_MIN;
            1: r.pri = PRI_MAX;
            2: r.pri = -1;
            3: r.pri = 0;
            default: r.pri = $urandom;
          endcase
        end
      endcase
      pending_reqs.push_back(r);
    end
    total = pending_reqs.size();

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Wait for every request beat to be taken and every answer to arrive.
    while (beats_taken < total) @(negedge clk);
    while (awaited_answers.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Run covered %0d request beats: %0d enqueues, %0d dequeues, peak occupancy %0d.",
             beats_taken, enq_count, deq_count, peak_occ);
    $display("Refused %0d enqueues at full and %0d dequeues at empty; %0d mismatches.",
             refused_full, refused_empty, mismatches);
    if (awaited_answers.size() != 0)
      $display("%0d expected answers never arrived", awaited_answers.size());
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
